FILE: rtl/tpdr_pkg.sv
// Shared types and codes for the tank pump dry-run controller.
`default_nettype none

package tpdr_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int GRACE_BITS     = 8;
    localparam int RUN_BITS       = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRY_RUN_GRACE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAUSE_TICKS   = 1'd1;

    localparam logic [GRACE_BITS-1:0]    GRACE_RESET       = 8'd1;
    localparam logic [CFG_DATA_BITS-1:0] PAUSE_TICKS_RESET = 16'd1800;
    localparam logic [RUN_BITS-1:0]      RUN_MAX           = 8'd255;

    localparam int EV_START_CHIRP = 0;
    localparam int EV_STOP_BEEP   = 1;
    localparam int EV_DRY_RUN     = 2;
    localparam int EV_FULL        = 3;
    localparam int EV_LOW_ALARM   = 4;

    localparam logic [1:0] LEVEL_FULL  = 2'd0;
    localparam logic [1:0] LEVEL_OKAY  = 2'd1;
    localparam logic [1:0] LEVEL_ERROR = 2'd2;
    localparam logic [1:0] LEVEL_LOW   = 2'd3;

    localparam logic [2:0] STATUS_IDLE_FULL   = 3'd0;
    localparam logic [2:0] STATUS_PRESS_START = 3'd1;
    localparam logic [2:0] STATUS_MONITORING  = 3'd2;
    localparam logic [2:0] STATUS_RUNNING     = 3'd3;
    localparam logic [2:0] STATUS_STOPPED     = 3'd4;
    localparam logic [2:0] STATUS_PAUSED      = 3'd5;

    typedef struct packed {
        logic start_pressed;
        logic stop_pressed;
        logic auto_enabled;
        logic flow_present;
        logic top_wet;
        logic bottom_wet;
    } in_item_t;

    typedef struct packed {
        logic       relay_on;
        logic [4:0] alarm_events;
        logic [1:0] level_code;
        logic [2:0] status_code;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/tank_pump_dry_run_controller.sv
// Top level: tank pump controller with dry-run pause, one sensor tick per request.
//
// Usage:
//   in_valid/in_ready/in_item carry one half-second sensor tick per request.
//   out_valid/out_ready/out_item return exactly one result per tick, in order.
//   cfg_write/cfg_index/cfg_data set the dry-run grace (index 0) and the
//   auto-restart pause length (index 1); write only while the block is idle.
// Path: a tick is held in the input register, and its result is then
//   registered in the result register, which drives out_item.
// Throughput: one tick per clock unless out_ready stalls; all pump rules are
//   evaluated in one pass of flag logic between the input and result registers.
// Reset: pump off, auto re-arm, full stop and low alarm armed, no pause,
//   grace = 1 tick, pause = 1800 ticks, both pipeline registers empty.
// Stall: while out_ready is low the result register holds; the input register
//   still takes one more tick, after which in_ready drops until space frees.
`default_nettype none

module tank_pump_dry_run_controller
    import tpdr_pkg::*;
#(
    parameter int PAUSE_BITS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_item,
    output logic                      out_valid,
    input  wire                       out_ready,
    output out_item_t                 out_item,
    input  wire                       cfg_write,
    input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire [CFG_DATA_BITS-1:0]   cfg_data
);

    logic [GRACE_BITS-1:0]    grace_reg;
    logic [CFG_DATA_BITS-1:0] pause_ticks_reg;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      s1_advance;

    logic                  pump_reg, pump_next;
    logic                  rearm_reg, rearm_next;
    logic                  full_armed_reg, full_armed_next;
    logic                  low_ok_reg, low_ok_next;
    logic [RUN_BITS-1:0]   run_reg, run_next;
    logic                  pause_reg, pause_next;
    logic [PAUSE_BITS-1:0] prem_reg, prem_next;
    logic                  shown_reg, shown_next;
    out_item_t             result;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg       <= GRACE_RESET;
            pause_ticks_reg <= PAUSE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DRY_RUN_GRACE: grace_reg <= cfg_data[GRACE_BITS-1:0];
                CFG_PAUSE_TICKS:   pause_ticks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // rule evaluation for the tick in the input register
    always_comb
    begin
        logic start, stop, autom, flow, top, bottom;
        logic stop_msg, do_tail, paused_now;
        logic [4:0] ev;
        logic [2:0] status;

        start  = s1_item_reg.start_pressed;
        stop   = s1_item_reg.stop_pressed;
        autom  = s1_item_reg.auto_enabled;
        flow   = s1_item_reg.flow_present;
        top    = s1_item_reg.top_wet;
        bottom = s1_item_reg.bottom_wet;

        pump_next       = pump_reg;
        rearm_next      = rearm_reg;
        full_armed_next = full_armed_reg;
        low_ok_next     = low_ok_reg;
        run_next        = run_reg;
        pause_next      = pause_reg;
        prem_next       = prem_reg;
        shown_next      = shown_reg;
        stop_msg        = 1'b0;
        do_tail         = 1'b0;
        paused_now      = 1'b0;
        ev              = '0;

        if (pause_reg)
        begin
            if (autom)
            begin
                if (prem_reg <= PAUSE_BITS'(1))
                begin
                    prem_next       = '0;
                    pump_next       = 1'b1;
                    shown_next      = 1'b0;
                    full_armed_next = 1'b1;
                    low_ok_next     = 1'b0;
                    do_tail         = 1'b1;
                end
                else
                begin
                    prem_next = prem_reg - PAUSE_BITS'(1);
                end
            end
            else if (start || stop)
            begin
                if (start)
                begin
                    pump_next       = 1'b1;
                    shown_next      = 1'b0;
                    full_armed_next = 1'b1;
                    low_ok_next     = 1'b0;
                end
                if (stop)
                begin
                    pump_next   = 1'b0;
                    low_ok_next = 1'b1;
                    run_next    = '0;
                    if (!shown_next)
                    begin
                        stop_msg   = 1'b1;
                        shown_next = 1'b1;
                    end
                end
                prem_next = '0;
                do_tail   = 1'b1;
            end
            else
            begin
                ev[EV_DRY_RUN] = 1'b1;
            end
            if (do_tail)
                pause_next = 1'b0;
        end
        else
        begin
            if (pump_reg && run_reg != RUN_MAX)
                run_next = run_reg + RUN_BITS'(1);
            if (autom)
            begin
                if (!top && rearm_reg)
                begin
                    pump_next       = 1'b1;
                    shown_next      = 1'b0;
                    full_armed_next = 1'b1;
                    low_ok_next     = 1'b0;
                    rearm_next      = 1'b0;
                end
                if (!bottom)
                    rearm_next = 1'b1;
            end
            if (start)
            begin
                ev[EV_START_CHIRP] = 1'b1;
                pump_next          = 1'b1;
                shown_next         = 1'b0;
                full_armed_next    = 1'b1;
                low_ok_next        = 1'b0;
            end
            if (stop)
            begin
                ev[EV_STOP_BEEP] = 1'b1;
                pump_next        = 1'b0;
                low_ok_next      = 1'b1;
                run_next         = '0;
                if (!shown_next)
                begin
                    stop_msg   = 1'b1;
                    shown_next = 1'b1;
                end
            end
            if (run_next > grace_reg && !flow && pump_next)
            begin
                ev[EV_DRY_RUN] = 1'b1;
                pump_next      = 1'b0;
                run_next       = '0;
                pause_next     = 1'b1;
                prem_next      = PAUSE_BITS'(pause_ticks_reg);
                paused_now     = 1'b1;
            end
            do_tail = !paused_now;
        end

        // full and low-level checks
        if (do_tail)
        begin
            if (top && full_armed_next)
            begin
                ev[EV_FULL]     = 1'b1;
                full_armed_next = 1'b0;
                pump_next       = 1'b0;
                low_ok_next     = 1'b1;
                run_next        = '0;
                if (!shown_next)
                begin
                    stop_msg   = 1'b1;
                    shown_next = 1'b1;
                end
            end
            if (!autom && !bottom && low_ok_next)
                ev[EV_LOW_ALARM] = 1'b1;
        end

        if (pause_next)
            status = STATUS_PAUSED;
        else if (pump_next)
            status = STATUS_RUNNING;
        else if (stop_msg)
            status = STATUS_STOPPED;
        else if (autom)
            status = STATUS_MONITORING;
        else if (top)
            status = STATUS_IDLE_FULL;
        else
            status = STATUS_PRESS_START;

        result.relay_on     = pump_next;
        result.alarm_events = ev;
        result.level_code   = top ? (bottom ? LEVEL_FULL : LEVEL_ERROR)
                                  : (bottom ? LEVEL_OKAY : LEVEL_LOW);
        result.status_code  = status;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_item;
    end

    // result register and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pump_reg       <= 1'b0;
            rearm_reg      <= 1'b1;
            full_armed_reg <= 1'b1;
            low_ok_reg     <= 1'b1;
            run_reg        <= '0;
            pause_reg      <= 1'b0;
            prem_reg       <= '0;
            shown_reg      <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                out_valid_reg  <= 1'b1;
                pump_reg       <= pump_next;
                rearm_reg      <= rearm_next;
                full_armed_reg <= full_armed_next;
                low_ok_reg     <= low_ok_next;
                run_reg        <= run_next;
                pause_reg      <= pause_next;
                prem_reg       <= prem_next;
                shown_reg      <= shown_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
            out_item_reg <= result;
    end

    // checks
    a_pause_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
        pause_reg |-> !pump_reg)
        else $error("pump running during dry-run pause");

    a_run_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pump_reg |-> (run_reg == '0))
        else $error("run count nonzero with pump off");

    a_relay_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.relay_on) |->
            (out_item_reg.status_code == STATUS_RUNNING))
        else $error("relay on without running status");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced tick produced no result");

endmodule

`default_nettype wire
